// ===== design/pfc_pkg.sv =====
// ---------------------------------------------------------------------------
// pfc_pkg - shared types, constants and helpers for the Playfair cipher
// Holds command codes, letter indexes, square geometry and the small
// row/column helpers used by the store, the geometry unit and the top level.
// ---------------------------------------------------------------------------
package pfc_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = SIDE * SIDE;
    localparam int LETTERS = 26;

    typedef logic [4:0] t_letter;
    typedef logic [4:0] t_cell;
    typedef logic [2:0] t_coord;
    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_KEY      = 2'd0;
    localparam t_cmd CMD_KEY_END  = 2'd1;
    localparam t_cmd CMD_TEXT     = 2'd2;
    localparam t_cmd CMD_TEXT_END = 2'd3;

    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam t_letter    IDX_Q    = 5'd16;
    localparam t_letter    IDX_X    = 5'd23;
    localparam logic [6:0] CASE_BIT = 7'h20;

    typedef struct packed {
        logic    place_en;
        t_letter place_idx;
        logic    clear;
    } t_store_ctl;

    // row of a cell: compare against the row starts
    function automatic t_coord f_row(input t_cell p);
        t_coord r;
        priority if (p >= 5'(4 * SIDE)) r = 3'd4;
        else if (p >= 5'(3 * SIDE))     r = 3'd3;
        else if (p >= 5'(2 * SIDE))     r = 3'd2;
        else if (p >= 5'(SIDE))         r = 3'd1;
        else                            r = 3'd0;
        return r;
    endfunction

    // cell index row*5+col without a multiplier
    function automatic t_cell f_cell(input t_coord row, input t_coord col);
        return 5'({row, 2'b00}) + 5'(row) + 5'(col);
    endfunction

    function automatic t_coord f_col(input t_cell p);
        return 3'(p - f_cell(f_row(p), 3'd0));
    endfunction

    // advance one place, wrapping at the edge of the square
    function automatic t_coord f_inc(input t_coord c);
        return (c == 3'(SIDE - 1)) ? 3'd0 : 3'(c + 3'd1);
    endfunction

    // letter index to uppercase ASCII
    function automatic logic [6:0] f_upper(input t_letter l);
        return (7'(CH_A) + 7'(l)) & ~CASE_BIT;
    endfunction

endpackage

// ===== design/pfc_req_if.sv =====
// ---------------------------------------------------------------------------
// pfc_req_if - request channel of the Playfair cipher
// Valid/ready channel carrying a command and one character.
// ---------------------------------------------------------------------------
interface pfc_req_if import pfc_pkg::*; ();
    logic       valid;
    logic       ready;
    t_cmd       cmd;
    logic [7:0] char_code;

    modport source (output valid, cmd, char_code, input ready);
    modport sink   (input valid, cmd, char_code, output ready);
endinterface

// ===== design/pfc_res_if.sv =====
// ---------------------------------------------------------------------------
// pfc_res_if - result channel of the Playfair cipher
// Valid/ready channel carrying one ciphertext letter and a pair-end flag.
// ---------------------------------------------------------------------------
interface pfc_res_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_of_run;

    modport source (output valid, out_char, last_of_run, input ready);
    modport sink   (input valid, out_char, last_of_run, output ready);
endinterface

// ===== design/pfc_store.sv =====
// ---------------------------------------------------------------------------
// pfc_store - key square store
// Holds the square and the letter positions in small memories with
// registered reads, plus the seen bits and fill count of the placement unit.
// ---------------------------------------------------------------------------
module pfc_store import pfc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_ctl i_ctl,
    input  t_letter    i_pos_raddr,
    output t_cell      o_pos_rdata,
    input  t_cell      i_sq_raddr,
    output t_letter    o_sq_rdata
);

    t_letter              mem_sq  [CELLS];
    t_cell                mem_pos [LETTERS];
    logic [LETTERS-1:0]   r_seen;
    t_cell                r_fill;
    t_cell                r_pos_rd;
    t_letter              r_sq_rd;
    logic                 w_place;

    // place only a fresh letter while a cell is free
    assign w_place = i_ctl.place_en && !r_seen[i_ctl.place_idx] &&
                     (r_fill < 5'(CELLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_fill <= '0;
        end else if (i_ctl.clear) begin
            r_seen <= '0;
            r_fill <= '0;
        end else if (w_place) begin
            r_seen[i_ctl.place_idx] <= 1'b1;
            r_fill <= 5'(r_fill + 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_place) begin
            mem_sq[r_fill]            <= i_ctl.place_idx;
            mem_pos[i_ctl.place_idx]  <= r_fill;
        end
        r_pos_rd <= mem_pos[i_pos_raddr];
        r_sq_rd  <= mem_sq[i_sq_raddr];
    end

    assign o_pos_rdata = r_pos_rd;
    assign o_sq_rdata  = r_sq_rd;

endmodule

// ===== design/pfc_geom.sv =====
// ---------------------------------------------------------------------------
// pfc_geom - digraph geometry unit
// Maps the square positions of a letter pair to the two cipher cells by the
// same-row, same-column and rectangle rules.
// ---------------------------------------------------------------------------
module pfc_geom import pfc_pkg::*; (
    input  t_cell i_pa,
    input  t_cell i_pb,
    output t_cell o_c0,
    output t_cell o_c1
);

    t_coord w_pr, w_pc, w_qr, w_qc;

    assign w_pr = f_row(i_pa);
    assign w_pc = f_col(i_pa);
    assign w_qr = f_row(i_pb);
    assign w_qc = f_col(i_pb);

    always_comb begin
        priority if (w_pr == w_qr) begin
            o_c0 = f_cell(w_pr, f_inc(w_pc));
            o_c1 = f_cell(w_qr, f_inc(w_qc));
        end else if (w_pc == w_qc) begin
            o_c0 = f_cell(f_inc(w_pr), w_pc);
            o_c1 = f_cell(f_inc(w_qr), w_qc);
        end else begin
            o_c0 = f_cell(w_pr, w_qc);
            o_c1 = f_cell(w_qr, w_pc);
        end
    end

endmodule

// ===== design/playfair_digraph_cipher_top.sv =====
// ---------------------------------------------------------------------------
// playfair_digraph_cipher_top - Playfair digraph encryption engine
// Key letters and other text requests are taken in S_IDLE. Key-end starts a
// 26-letter fill sweep in S_FILL. A request that closes a pair runs the position
// reads, the geometry step and the square reads, then one result per cycle as taken.
// Synchronous active-low reset clears the sequencer, pending letter, seen bits
// and fill count; the square memories need no clearing.
// ---------------------------------------------------------------------------
module playfair_digraph_cipher_top import pfc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pfc_req_if.sink       i_req,
    pfc_res_if.source     o_res
);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILL = 4'd1;
    localparam logic [3:0] S_RDA  = 4'd2;
    localparam logic [3:0] S_RDB  = 4'd3;
    localparam logic [3:0] S_GEO  = 4'd4;
    localparam logic [3:0] S_SQ0  = 4'd5;
    localparam logic [3:0] S_SQ1  = 4'd6;
    localparam logic [3:0] S_LD1  = 4'd7;
    localparam logic [3:0] S_OUT0 = 4'd8;
    localparam logic [3:0] S_OUT1 = 4'd9;

    logic [3:0]  r_state, n_state;
    t_letter     r_fi;            // fill sweep letter
    t_letter     r_pend_letter;
    logic        r_pend_valid;
    t_letter     r_a, r_b;        // pair being encrypted
    t_cell       r_pa;            // square position of the first letter
    t_cell       r_c0, r_c1;      // cipher cells
    t_letter     r_l0, r_l1;      // cipher letters

    logic        w_acc;
    logic        w_is_letter;
    t_letter     w_idx;
    t_store_ctl  w_ctl;
    t_letter     w_pos_raddr;
    t_cell       w_pos_rdata;
    t_cell       w_sq_raddr;
    t_letter     w_sq_rdata;
    t_cell       w_c0, w_c1;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_is_letter = (i_req.char_code >= CH_A) && (i_req.char_code <= CH_Z);
    assign w_idx       = 5'(i_req.char_code - CH_A);

    // Drive the shared placement unit: from the sweep while filling, else from
    // an accepted key letter. Text-end clears the seen bits and fill count.
    always_comb begin
        w_ctl.place_en  = ((r_state == S_FILL) && (r_fi != IDX_Q)) ||
                          (w_acc && (i_req.cmd == CMD_KEY) && w_is_letter);
        w_ctl.place_idx = (r_state == S_FILL) ? r_fi : w_idx;
        w_ctl.clear     = w_acc && (i_req.cmd == CMD_TEXT_END);
    end

    // one position read, then the other, over the same port
    assign w_pos_raddr = (r_state == S_RDB) ? r_b : r_a;
    assign w_sq_raddr  = (r_state == S_SQ1) ? r_c1 : r_c0;

    pfc_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_pos_raddr (w_pos_raddr),
        .o_pos_rdata (w_pos_rdata),
        .i_sq_raddr  (w_sq_raddr),
        .o_sq_rdata  (w_sq_rdata)
    );

    // second position arrives straight from the memory register in S_GEO
    pfc_geom u_geom (
        .i_pa (r_pa),
        .i_pb (w_pos_rdata),
        .o_c0 (w_c0),
        .o_c1 (w_c1)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_req.cmd)
                        CMD_KEY:      n_state = S_IDLE;
                        CMD_KEY_END:  n_state = S_FILL;
                        CMD_TEXT:     if (w_is_letter && r_pend_valid) n_state = S_RDA;
                        CMD_TEXT_END: if (r_pend_valid) n_state = S_RDA;
                    endcase
                end
            end
            S_FILL: if (r_fi == 5'(LETTERS - 1)) n_state = S_IDLE;
            S_RDA:  n_state = S_RDB;
            S_RDB:  n_state = S_GEO;
            S_GEO:  n_state = S_SQ0;
            S_SQ0:  n_state = S_SQ1;
            S_SQ1:  n_state = S_LD1;
            S_LD1:  n_state = S_OUT0;
            S_OUT0: if (o_res.ready) n_state = S_OUT1;
            S_OUT1: if (o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_fi          <= '0;
            r_pend_letter <= '0;
            r_pend_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FILL) begin
                r_fi <= 5'(r_fi + 5'd1);
            end
            if (w_acc) begin
                unique case (i_req.cmd)
                    CMD_KEY_END: r_fi <= '0;
                    CMD_TEXT: begin
                        // hold the first letter; a doubled letter starts the next pair
                        if (w_is_letter) begin
                            if (!r_pend_valid || (r_pend_letter == w_idx)) begin
                                r_pend_letter <= w_idx;
                                r_pend_valid  <= 1'b1;
                            end else begin
                                r_pend_letter <= '0;
                                r_pend_valid  <= 1'b0;
                            end
                        end
                    end
                    CMD_TEXT_END: begin
                        // drop the pending letter once its pair is under way
                        r_pend_letter <= '0;
                        r_pend_valid  <= 1'b0;
                    end
                    CMD_KEY: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_a <= r_pend_letter;
            // pad with x on a doubled letter or at text end
            r_b <= ((i_req.cmd == CMD_TEXT) && (w_idx != r_pend_letter)) ? w_idx : IDX_X;
        end
        if (r_state == S_RDB) r_pa <= w_pos_rdata;
        if (r_state == S_GEO) begin
            r_c0 <= w_c0;
            r_c1 <= w_c1;
        end
        if (r_state == S_SQ1) r_l0 <= w_sq_rdata;
        if (r_state == S_LD1) r_l1 <= w_sq_rdata;
    end

    // results leave from registers, first letter then second
    assign o_res.valid       = (r_state == S_OUT0) || (r_state == S_OUT1);
    assign o_res.last_of_run = (r_state == S_OUT1);
    assign o_res.out_char    = (r_state == S_OUT1) ? f_upper(r_l1) : f_upper(r_l0);

    // no new request while a result is on offer
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_req.ready)
        else $error("request taken while a result is pending");

    // text end always leaves nothing pending
    a_text_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_req.cmd == CMD_TEXT_END)) |=> !r_pend_valid)
        else $error("pending letter survived text end");

    // taking the second letter of a pair frees the block
    a_pair_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.last_of_run) |=> i_req.ready)
        else $error("block not idle after pair");

    // fill sweep stays within the alphabet
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_fi < 5'(LETTERS)))
        else $error("fill sweep ran past the alphabet");

endmodule

// ===== bench/tb_playfair_digraph_cipher_top.sv =====
// ---------------------------------------------------------------------------
// tb_playfair_digraph_cipher_top - self-checking bench for the Playfair engine
// Feeds keys, key-ends, text and text-ends through the request channel,
// works out the expected ciphertext letters for every accepted request and
// compares them, in order, with what leaves the result channel. Both sides
// idle and stall at random in phases.
// ---------------------------------------------------------------------------
module tb_playfair_digraph_cipher_top;
    import pfc_pkg::*;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] code;
        bit         drain;   // marker: hold the sender until all letters are back
    } t_req_item;

    typedef struct {
        logic [6:0] letter;
        logic       last;
    } t_cipher_out;

    logic i_clk;
    logic i_rst_n;

    pfc_req_if req_if ();
    pfc_res_if res_if ();

    playfair_digraph_cipher_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    // requests still to send, and ciphertext letters still to arrive
    t_req_item   req_stream [$];
    t_cipher_out cipher_due [$];

    int req_total;       // requests placed in the stream
    int req_count;       // requests accepted by the block
    int err_count;
    bit req_taken;       // request accepted at the last rising edge
    bit hold_res;        // long receiver hold-off

    // expected-state copy of the square
    t_letter sq_letter   [CELLS];
    t_cell   letter_cell [LETTERS];
    bit      placed      [LETTERS];
    int      cells_used;
    t_letter held_letter;
    bit      held_valid;

    // letters that the stimulus knows are in the square, so that text
    // never asks for a cell that was not written
    bit square_has [LETTERS];
    int square_fill;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // -----------------------------------------------------------------------
    // Expected behaviour
    // -----------------------------------------------------------------------
    function automatic void seat_letter(input int l);
        if (!placed[l] && cells_used < CELLS) begin
            placed[l]             = 1'b1;
            letter_cell[l]        = t_cell'(cells_used);
            sq_letter[cells_used] = t_letter'(l);
            cells_used++;
        end
    endfunction

    function automatic logic [6:0] upper_at(input int row, input int col);
        return 7'h41 + 7'(sq_letter[(row % SIDE) * SIDE + (col % SIDE)]);
    endfunction

    // encrypt one pair and queue both output letters
    function automatic void encipher_pair(input t_letter a, input t_letter b);
        int         ra, ca, rb, cb;
        logic [6:0] c0, c1;
        ra = int'(letter_cell[a]) / SIDE;
        ca = int'(letter_cell[a]) % SIDE;
        rb = int'(letter_cell[b]) / SIDE;
        cb = int'(letter_cell[b]) % SIDE;
        if (ra == rb) begin
            c0 = upper_at(ra, ca + 1);
            c1 = upper_at(rb, cb + 1);
        end else if (ca == cb) begin
            c0 = upper_at(ra + 1, ca);
            c1 = upper_at(rb + 1, cb);
        end else begin
            // rectangle: each letter takes the other's column
            c0 = upper_at(ra, cb);
            c1 = upper_at(rb, ca);
        end
        cipher_due.push_back('{letter: c0, last: 1'b0});
        cipher_due.push_back('{letter: c1, last: 1'b1});
    endfunction

    function automatic void predict_cipher(input t_cmd cmd, input logic [7:0] code);
        bit      is_letter;
        t_letter l;
        is_letter = (code >= CH_A) && (code <= CH_Z);
        l         = is_letter ? t_letter'(code - CH_A) : t_letter'(0);
        case (cmd)
            CMD_KEY: begin
                if (is_letter) seat_letter(l);
            end
            CMD_KEY_END: begin
                for (int i = 0; i < LETTERS; i++)
                    if (i != int'(IDX_Q)) seat_letter(i);
            end
            CMD_TEXT: begin
                if (is_letter) begin
                    if (!held_valid) begin
                        held_letter = l;
                        held_valid  = 1'b1;
                    end else if (held_letter == l) begin
                        // doubled letter: pad with x, the repeat opens the next pair
                        encipher_pair(held_letter, IDX_X);
                    end else begin
                        encipher_pair(held_letter, l);
                        held_valid  = 1'b0;
                        held_letter = '0;
                    end
                end
            end
            default: begin
                if (held_valid) encipher_pair(held_letter, IDX_X);
                held_valid  = 1'b0;
                held_letter = '0;
                placed      = '{default: 1'b0};
                cells_used  = 0;
            end
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic void push_req(input t_cmd c, input logic [7:0] code);
        bit is_letter;
        int l;
        is_letter = (code >= CH_A) && (code <= CH_Z);
        l         = int'(code) - int'(CH_A);
        req_stream.push_back('{cmd: c, code: code, drain: 1'b0});
        req_total++;
        case (c)
            CMD_KEY: begin
                if (is_letter && !square_has[l] && square_fill < CELLS) begin
                    square_has[l] = 1'b1;
                    square_fill++;
                end
            end
            CMD_KEY_END: begin
                for (int i = 0; i < LETTERS; i++) begin
                    if (i != int'(IDX_Q) && !square_has[i] && square_fill < CELLS) begin
                        square_has[i] = 1'b1;
                        square_fill++;
                    end
                end
            end
            CMD_TEXT: ;
            default: begin
                square_has  = '{default: 1'b0};
                square_fill = 0;
            end
        endcase
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        if ($urandom_range(0, 2) == 0) return 8'h20;
        do c = 8'($urandom_range(0, 255)); while (c >= CH_A && c <= CH_Z);
        return c;
    endfunction

    function automatic logic [7:0] letter_code(input int l);
        return CH_A + 8'(l);
    endfunction

    // text letter from the square, repeating the previous one now and then
    function automatic int pick_plain(input int prev);
        int l;
        if (prev >= 0 && $urandom_range(0, 3) == 0) return prev;
        do l = $urandom_range(0, LETTERS - 1); while (!square_has[l]);
        return l;
    endfunction

    // one key, its fill, a stretch of text and a text-end; some are left broken
    task automatic add_session();
        int kind, n, prev, l, j, tmp;
        int key_l [$];
        int order [LETTERS];
        bit has_q;
        kind = $urandom_range(0, 11);
        if (kind == 0) begin
            // abandoned key: drop it with a text-end before any fill
            n = $urandom_range(0, 6);
            repeat (n) push_req(CMD_KEY, letter_code($urandom_range(0, LETTERS - 1)));
            if ($urandom_range(0, 1)) push_req(CMD_TEXT, noise_char());
            push_req(CMD_TEXT_END, 8'($urandom_range(0, 255)));
            return;
        end
        if (kind == 1) begin
            // every letter in the key: the square fills before the key ends
            for (int i = 0; i < LETTERS; i++) order[i] = i;
            for (int i = LETTERS - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < LETTERS; i++) key_l.push_back(order[i]);
            repeat ($urandom_range(0, 4)) key_l.push_back($urandom_range(0, LETTERS - 1));
        end else begin
            n = $urandom_range(0, 12);
            repeat (n) key_l.push_back($urandom_range(0, LETTERS - 1));
            if ($urandom_range(0, 3) == 0)
                key_l.insert($urandom_range(0, key_l.size()), int'(IDX_Q));
        end
        // with q in the key one letter drops out; keep x in so padding works
        has_q = 1'b0;
        foreach (key_l[i]) if (key_l[i] == int'(IDX_Q)) has_q = 1'b1;
        if (has_q) key_l.push_front(int'(IDX_X));
        foreach (key_l[i]) begin
            if ($urandom_range(0, 5) == 0) push_req(CMD_KEY, noise_char());
            push_req(CMD_KEY, letter_code(key_l[i]));
        end
        push_req(CMD_KEY_END, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0) push_req(CMD_KEY_END, 8'($urandom_range(0, 255)));

        n    = $urandom_range(1, 24);
        prev = -1;
        repeat (n) begin
            if ($urandom_range(0, 7) == 0) push_req(CMD_TEXT, noise_char());
            if ($urandom_range(0, 19) == 0) begin
                // key traffic in mid-text leaves the pending letter alone
                if ($urandom_range(0, 1))
                    push_req(CMD_KEY, letter_code($urandom_range(0, LETTERS - 1)));
                else
                    push_req(CMD_KEY_END, 8'($urandom_range(0, 255)));
            end
            l = pick_plain(prev);
            push_req(CMD_TEXT, letter_code(l));
            prev = l;
        end
        push_req(CMD_TEXT_END, 8'($urandom_range(0, 255)));
    endtask

    // -----------------------------------------------------------------------
    // Idling phases, stepped by accepted requests
    // -----------------------------------------------------------------------
    function automatic int idle_phase();
        return (req_count / 120) % 4;
    endfunction

    // -----------------------------------------------------------------------
    // Request driver: change inputs on the falling edge, hold until accepted
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_req_item nxt;
        int        gap_pct;
        if (i_rst_n && !(req_if.valid && !req_taken)) begin
            gap_pct = (idle_phase() == 1) ? 46 : (idle_phase() == 3) ? 20 : 0;
            // a drain marker holds the sender until every letter has come back
            if (req_stream.size() != 0 && req_stream[0].drain && cipher_due.size() == 0)
                void'(req_stream.pop_front());
            if (req_stream.size() != 0 && !req_stream[0].drain &&
                $urandom_range(0, 99) >= gap_pct) begin
                nxt               = req_stream.pop_front();
                req_if.valid     <= 1'b1;
                req_if.cmd       <= nxt.cmd;
                req_if.char_code <= nxt.code;
            end else begin
                // idle: scramble the payload so nothing relies on it
                req_if.valid     <= 1'b0;
                req_if.cmd       <= t_cmd'($urandom_range(0, 3));
                req_if.char_code <= 8'($urandom_range(0, 255));
            end
        end
    end

    // Result receiver: random stalls by phase, plus the long hold-off
    always @(negedge i_clk) begin
        int stall_pct;
        stall_pct = (idle_phase() == 2) ? 46 : (idle_phase() == 3) ? 20 : 0;
        if (!i_rst_n || hold_res)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // -----------------------------------------------------------------------
    // Monitor: sample on the rising edge, check results, then predict
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cipher_out due;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_if.valid && req_if.ready;
            if (res_if.valid && res_if.ready) begin
                if (cipher_due.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result '%c' last=%0b", res_if.out_char,
                                 res_if.last_of_run);
                end else begin
                    due = cipher_due.pop_front();
                    if (res_if.out_char !== due.letter || res_if.last_of_run !== due.last) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("mismatch: expected '%c' last=%0b, got '%c' (%h) last=%0b",
                                     due.letter, due.last, res_if.out_char,
                                     res_if.out_char, res_if.last_of_run);
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                predict_cipher(req_if.cmd, req_if.char_code);
                req_count++;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Reset and known input values from time zero
    // -----------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.cmd       = CMD_KEY;
        req_if.char_code = 8'h00;
        res_if.ready     = 1'b0;
        hold_res         = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Long receiver hold-off while the sender keeps offering requests
    initial begin
        wait (req_count >= 300);
        hold_res = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_res = 1'b0;
    end

    // Run limit
    initial begin
        #(400000 * 8);
        $display("CHECK FAILED");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run
    // -----------------------------------------------------------------------
    initial begin
        bit drained;
        drained = 1'b0;

        // directed: text-end with nothing pending, ignored characters at the
        // edges of the letter range, q in the key and a repeated key-end
        push_req(CMD_TEXT_END, 8'hFF);
        push_req(CMD_TEXT, 8'h00);
        push_req(CMD_KEY, 8'h20);
        push_req(CMD_KEY, 8'h60);
        push_req(CMD_KEY, 8'h7B);
        push_req(CMD_KEY, "q");
        push_req(CMD_KEY, "q");
        push_req(CMD_KEY_END, 8'h80);
        push_req(CMD_KEY_END, 8'h7F);
        // square rows: q a b c d / e f g h i / j k l m n / o p r s t / u v w x y
        push_req(CMD_TEXT, "a");   // same row
        push_req(CMD_TEXT, "b");
        push_req(CMD_TEXT, "q");   // same column
        push_req(CMD_TEXT, "e");
        push_req(CMD_TEXT, "a");   // rectangle
        push_req(CMD_TEXT, "g");
        push_req(CMD_TEXT, "d");   // row wrap
        push_req(CMD_TEXT, "q");
        push_req(CMD_TEXT, "u");   // column wrap
        push_req(CMD_TEXT, "q");
        push_req(CMD_TEXT, "y");   // doubled letter, then one left pending
        push_req(CMD_TEXT, "y");
        push_req(CMD_KEY, "m");    // key traffic with a letter pending
        push_req(CMD_TEXT, " ");
        push_req(CMD_TEXT_END, 8'h00);

        // random sessions; drain the block once part-way through
        while (req_total < 850) begin
            add_session();
            if (!drained && req_total >= 550) begin
                req_stream.push_back('{cmd: CMD_KEY, code: 8'h00, drain: 1'b1});
                drained = 1'b1;
            end
        end

        // wait for every request to be taken and every letter to come back
        while (req_count < req_total) @(negedge i_clk);
        while (cipher_due.size() != 0) @(negedge i_clk);
        // allow for a fill sweep or a late stray result
        repeat (60) @(negedge i_clk);

        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/pfc_pkg.sv
design/pfc_req_if.sv
design/pfc_res_if.sv
design/pfc_store.sv
design/pfc_geom.sv
design/playfair_digraph_cipher_top.sv
bench/tb_playfair_digraph_cipher_top.sv
